/* hdl/xed_pkg.sv */
// Shared types and constants for the XML entity decoder.
// Holds the entity table and the queue entry format; no dependencies.
`default_nettype none

package xed_pkg;

  localparam int unsigned NumEnt    = 12;
  localparam int unsigned MaxBody   = 5;
  localparam int unsigned HeldDepth = 4;
  localparam int unsigned EntBytes  = 6;

  localparam logic [7:0] ChAmp = 8'h26;

  localparam logic [7:0] EntBody [NumEnt][MaxBody] = '{
    '{"q", "u", "o", "t", ";"},
    '{"a", "p", "o", "s", ";"},
    '{"a", "m", "p", ";", 8'h00},
    '{"l", "t", ";", 8'h00, 8'h00},
    '{"g", "t", ";", 8'h00, 8'h00},
    '{"#", "3", "4", ";", 8'h00},
    '{"#", "3", "9", ";", 8'h00},
    '{"#", "3", "8", ";", 8'h00},
    '{"#", "6", "0", ";", 8'h00},
    '{"#", "6", "2", ";", 8'h00},
    '{"#", "1", "2", "3", ";"},
    '{"#", "1", "2", "5", ";"}
  };

  localparam logic [2:0] EntLen [NumEnt] = '{
    3'd5, 3'd5, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5
  };

  localparam logic [7:0] EntChar [NumEnt] = '{
    8'h22, 8'h27, 8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h26, 8'h3c, 8'h3e,
    8'h7b, 8'h7d
  };

  // One step's worth of output bytes, emitted from index 0 upward.
  typedef struct packed {
    logic [EntBytes-1:0][7:0] chars;
    logic [2:0]               cnt;
    logic                     last;
  } xed_entry_t;

endpackage

`default_nettype wire

/* hdl/xed_front.sv */
// Front end: accepts input beats, tracks the pending entity prefix and
// builds one queue entry per beat. Depends on xed_pkg.
`default_nettype none

module xed_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] in_byte
  input  wire logic              s_axis_tlast,
  input  wire logic              space_i,
  output logic                   push_o,
  output xed_pkg::xed_entry_t    entry_o
);
  import xed_pkg::*;

  logic [2:0]       held_cnt_q, held_cnt_d;
  logic [7:0]       held_q [HeldDepth];
  logic [2:0]       hl;
  logic             accept;
  logic             is_amp;
  logic             prefix;
  logic             match;
  logic [7:0]       match_char;
  logic             ent_ok;
  logic [7:0]       b;
  xed_entry_t       entry;

  assign b             = s_axis_tdata;
  assign s_axis_tready = space_i;
  assign accept        = s_axis_tvalid & space_i;
  assign hl            = held_cnt_q - 3'd1;
  assign is_amp        = (b == ChAmp);

  always_comb begin
    prefix     = 1'b0;
    match      = 1'b0;
    match_char = 8'h00;
    for (int e = 0; e < NumEnt; e++) begin
      ent_ok = ((hl + 3'd1) <= EntLen[e]);
      for (int i = 0; i < MaxBody; i++) begin
        if (3'(i) < hl) begin
          if (i < HeldDepth) begin
            if (EntBody[e][i] != held_q[i[1:0]]) ent_ok = 1'b0;
          end
        end else if (3'(i) == hl) begin
          if (EntBody[e][i] != b) ent_ok = 1'b0;
        end
      end
      if (ent_ok) begin
        prefix = 1'b1;
        if ((hl + 3'd1) == EntLen[e]) begin
          match      = 1'b1;
          match_char = EntChar[e];
        end
      end
    end
  end

  always_comb begin
    entry       = '0;
    entry.last  = s_axis_tlast;
    held_cnt_d  = held_cnt_q;
    // flush layout: ampersand, held bytes, then the new byte
    entry.chars[0] = ChAmp;
    for (int i = 1; i < EntBytes - 1; i++) begin
      entry.chars[i] = (3'(i - 1) < hl) ? held_q[2'(i - 1)] : b;
    end
    entry.chars[EntBytes-1] = b;
    if (held_cnt_q != 3'd0) begin
      if (match) begin
        entry.chars[0] = match_char;
        entry.cnt      = 3'd1;
        held_cnt_d     = 3'd0;
      end else if (prefix && (hl < 3'(HeldDepth))) begin
        if (s_axis_tlast) begin
          entry.cnt  = hl + 3'd2;
          held_cnt_d = 3'd0;
        end else begin
          entry.cnt  = 3'd0;
          held_cnt_d = held_cnt_q + 3'd1;
        end
      end else if (is_amp && !s_axis_tlast) begin
        entry.cnt  = hl + 3'd1;
        held_cnt_d = 3'd1;
      end else begin
        entry.cnt  = hl + 3'd2;
        held_cnt_d = 3'd0;
      end
    end else if (is_amp && !s_axis_tlast) begin
      entry.cnt  = 3'd0;
      held_cnt_d = 3'd1;
    end else begin
      entry.chars[0] = b;
      entry.cnt      = 3'd1;
      held_cnt_d     = 3'd0;
    end
  end

  assign entry_o = entry;
  assign push_o  = accept && (entry.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 3'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (held_cnt_q != 3'd0) && !match && prefix && (hl < 3'(HeldDepth))) begin
      held_q[hl[1:0]] <= b;
    end
  end

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= 3'd5)
    else $error("held count out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |=> held_cnt_q == 3'd0)
    else $error("prefix held across end of string");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |-> push_o)
    else $error("final beat produced no output");

endmodule

`default_nettype wire

/* hdl/xed_queue.sv */
// Short entry queue between the front end and the output serializer.
// Register array with head read; depends on xed_pkg.
`default_nettype none

module xed_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire xed_pkg::xed_entry_t wdata_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output xed_pkg::xed_entry_t    rdata_o
);
  import xed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xed_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign space_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("queue push while full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == CntW'(Depth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

/* hdl/xed_back.sv */
// Output serializer: walks the head queue entry one byte per beat.
// Depends on xed_pkg.
`default_nettype none

module xed_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire xed_pkg::xed_entry_t entry_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
  output logic                   m_axis_tlast
);
  import xed_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       at_end;
  logic       fire;

  assign at_end        = (idx_q == (entry_i.cnt - 3'd1));
  assign fire          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = valid_i;
  assign m_axis_tdata  = entry_i.chars[idx_q];
  assign m_axis_tlast  = entry_i.last && at_end;
  assign pop_o         = fire && at_end;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = at_end ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (idx_q < entry_i.cnt) && (entry_i.cnt <= 3'(EntBytes)))
    else $error("byte index beyond entry");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> idx_q == 3'd0)
    else $error("index left mid-entry with queue empty");

  a_pop_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 3'd0)
    else $error("index not rewound after entry");

endmodule

`default_nettype wire

/* hdl/xml_entity_decoder_top.sv */
// XML entity decoder top level: front end, entry queue, output serializer.
// Depends on xed_pkg, xed_front, xed_queue and xed_back.
//
// Usage:
//  s_axis carries one text byte per beat, tlast on the final byte of a string.
//  m_axis carries the decoded bytes, tlast on the final byte of the string.
//  The front end takes a byte every cycle while the queue has room; each
//  beat with output becomes one queue entry of one to six bytes (a decoded
//  entity, a plain byte, or a failed prefix flushed as it came).
//  Each entry is registered in the queue before m_axis offers its bytes.
//  Throughput: one input beat per cycle as long as each yields at most one
//  output byte and the receiver keeps up; an entry goes out one byte per
//  output beat, and with QueueDepth entries waiting s_axis_tready drops.
//  When the receiver stalls, the head byte holds and the queue fills, then
//  input backpressure follows.
//  Reset clears the held prefix and empties the queue; nothing is emitted.
`default_nettype none

module xml_entity_decoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast    // out_last
);
  import xed_pkg::*;

  xed_entry_t push_entry;
  xed_entry_t head_entry;
  logic       push;
  logic       space;
  logic       head_valid;
  logic       pop;

  xed_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .space_i       (space),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  xed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .space_o (space),
    .valid_o (head_valid),
    .pop_i   (pop),
    .rdata_o (head_entry)
  );

  xed_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (head_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
